// File: sv/cebu_pkg.sv
// shared types and constants for the edge coverage bitmap update block
package cebu_pkg;

	localparam int SLOT_W = 16;

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_READ   = 1'b1;

	localparam logic [63:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_MUL_B   = 64'h94d049bb133111eb;
	localparam logic [63:0] COMBINE_ADD = 64'h0000_0000_9e37_79b9;

	localparam int SHIFT_PRE  = 30;
	localparam int SHIFT_MID  = 27;
	localparam int SHIFT_POST = 31;
	localparam int SHIFT_UP   = 6;
	localparam int SHIFT_DOWN = 2;

	localparam logic [7:0] COUNT_MAX   = 8'd255;
	localparam logic [7:0] COUNT_FLOOR = 8'd128;

	typedef logic [SLOT_W-1:0] slot_t;

	typedef struct packed {
		logic        opcode;
		logic [63:0] location;
		logic        first_of_trace;
		logic [15:0] entry_index;
	} req_t;

	typedef struct packed {
		logic [15:0] slot_index;
		logic [7:0]  count_value;
		logic        wrapped;
	} res_t;

	typedef struct packed {
		logic  start;
		logic  record;
		slot_t slot;
	} map_req_t;

	typedef struct packed {
		logic       done;
		slot_t      slot;
		logic [7:0] count;
		logic       wrapped;
	} map_res_t;

endpackage

// File: sv/cebu_mul.sv
// shared 32 x 32 multiplier with registered product
module cebu_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= {32'd0, a} * {32'd0, b};
	end

endmodule

// File: sv/cebu_slot.sv
// location hash, combine with previous hash and reduction to a bitmap slot
module cebu_slot #(
	parameter int MAP_ENTRIES = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  cebu_pkg::req_t     item,
	output cebu_pkg::map_req_t slot_req
);

	localparam int IDX_W = $clog2(MAP_ENTRIES);
	localparam bit POW2  = (MAP_ENTRIES & (MAP_ENTRIES - 1)) == 0;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MUL_A = 3'd1;
	localparam logic [2:0] S_MUL_B = 3'd2;
	localparam logic [2:0] S_SUM_P = 3'd3;
	localparam logic [2:0] S_SUM_L = 3'd4;
	localparam logic [2:0] S_SUM_R = 3'd5;
	localparam logic [2:0] S_MOD   = 3'd6;

	logic [2:0]       state_q;
	logic [6:0]       cnt_q;
	logic [63:0]      x_q;
	logic [63:0]      acc_q;
	logic [63:0]      h_q;
	logic [63:0]      p_q;
	logic [63:0]      prev_q;
	logic [63:0]      sh_q;
	logic [IDX_W-1:0] r_q;
	logic             rec_q;
	logic             done_q;
	cebu_pkg::slot_t  slot_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic [63:0] k;
	logic [31:0] hi_sum;
	logic [63:0] mul_res;
	logic [63:0] mixed;
	logic [IDX_W:0]   sr;
	logic [IDX_W-1:0] r_next;

	cebu_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

	always_comb begin
		k = (state_q == S_MUL_A) ? cebu_pkg::MIX_MUL_A : cebu_pkg::MIX_MUL_B;
		case (cnt_q[1:0])
			2'd0: begin
				mul_a = x_q[31:0];
				mul_b = k[31:0];
			end
			2'd1: begin
				mul_a = x_q[63:32];
				mul_b = k[31:0];
			end
			default: begin
				mul_a = x_q[31:0];
				mul_b = k[63:32];
			end
		endcase
		hi_sum  = acc_q[63:32] + prod[31:0];
		mul_res = {hi_sum, acc_q[31:0]};
		mixed   = h_q ^ (acc_q + (h_q >> cebu_pkg::SHIFT_DOWN));
		sr      = {r_q, sh_q[63]};
		if (sr >= (IDX_W+1)'(MAP_ENTRIES)) begin
			sr = sr - (IDX_W+1)'(MAP_ENTRIES);
		end
		r_next = sr[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			prev_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					done_q <= start && (item.opcode == cebu_pkg::OP_READ) && POW2;
					if (start) begin
						if (item.opcode == cebu_pkg::OP_READ) begin
							if (POW2) begin
								cnt_q <= '0;
							end else begin
								cnt_q   <= 7'd16;
								state_q <= S_MOD;
							end
						end else begin
							cnt_q   <= '0;
							state_q <= S_MUL_A;
						end
					end
				end
				S_MUL_A, S_MUL_B: begin
					if (cnt_q[1:0] == 2'd3) begin
						cnt_q <= '0;
						if (state_q == S_MUL_A) begin
							state_q <= S_MUL_B;
						end else begin
							prev_q  <= mul_res ^ (mul_res >> cebu_pkg::SHIFT_POST);
							state_q <= S_SUM_P;
						end
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				S_SUM_P: begin
					state_q <= S_SUM_L;
				end
				S_SUM_L: begin
					state_q <= S_SUM_R;
				end
				S_SUM_R: begin
					done_q <= POW2;
					if (POW2) begin
						state_q <= S_IDLE;
					end else begin
						cnt_q   <= 7'd64;
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					done_q <= (cnt_q == 7'd1);
					cnt_q  <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					rec_q <= (item.opcode == cebu_pkg::OP_RECORD);
					x_q   <= item.location ^ (item.location >> cebu_pkg::SHIFT_PRE);
					p_q   <= item.first_of_trace ? 64'd0 : prev_q;
					sh_q  <= {item.entry_index, 48'd0};
					r_q   <= '0;
					slot_q <= cebu_pkg::slot_t'(item.entry_index[IDX_W-1:0]);
				end
			end
			S_MUL_A, S_MUL_B: begin
				case (cnt_q[1:0])
					2'd1: begin
						acc_q <= prod;
					end
					2'd2: begin
						acc_q[63:32] <= hi_sum;
					end
					2'd3: begin
						if (state_q == S_MUL_A) begin
							x_q <= mul_res ^ (mul_res >> cebu_pkg::SHIFT_MID);
						end else begin
							h_q <= mul_res ^ (mul_res >> cebu_pkg::SHIFT_POST);
						end
					end
					default: begin
						acc_q <= acc_q;
					end
				endcase
			end
			S_SUM_P: begin
				acc_q <= p_q + cebu_pkg::COMBINE_ADD;
			end
			S_SUM_L: begin
				acc_q <= acc_q + (h_q << cebu_pkg::SHIFT_UP);
			end
			S_SUM_R: begin
				sh_q   <= mixed;
				r_q    <= '0;
				slot_q <= cebu_pkg::slot_t'(mixed[IDX_W-1:0]);
			end
			S_MOD: begin
				r_q    <= r_next;
				sh_q   <= {sh_q[62:0], 1'b0};
				slot_q <= cebu_pkg::slot_t'(r_next);
			end
			default: begin
				r_q <= r_q;
			end
		endcase
	end

	assign slot_req = '{start: done_q, record: rec_q, slot: slot_q};

endmodule

// File: sv/cebu_map.sv
// byte counter bitmap with clearing pass and read-modify-write sequencer
module cebu_map #(
	parameter int MAP_ENTRIES = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cebu_pkg::map_req_t req,
	input  logic               ack,
	output cebu_pkg::map_res_t res,
	output logic               clearing
);

	localparam int IDX_W = $clog2(MAP_ENTRIES);

	localparam logic [2:0] M_CLEAR = 3'd0;
	localparam logic [2:0] M_IDLE  = 3'd1;
	localparam logic [2:0] M_READ  = 3'd2;
	localparam logic [2:0] M_UPD   = 3'd3;
	localparam logic [2:0] M_HOLD  = 3'd4;

	logic [7:0] mem [MAP_ENTRIES];

	logic [2:0]       state_q;
	logic [IDX_W-1:0] clr_q;
	logic [IDX_W-1:0] addr_q;
	logic             rec_q;
	logic [7:0]       rd_q;
	logic [7:0]       count_q;
	logic             wrap_q;

	logic             we;
	logic [IDX_W-1:0] wa;
	logic [7:0]       wd;
	logic             at_max;
	logic [7:0]       bumped;

	always_comb begin
		at_max = (rd_q == cebu_pkg::COUNT_MAX);
		bumped = at_max ? cebu_pkg::COUNT_FLOOR : rd_q + 8'd1;
		we     = (state_q == M_CLEAR) || ((state_q == M_UPD) && rec_q);
		wa     = (state_q == M_CLEAR) ? clr_q : addr_q;
		wd     = (state_q == M_CLEAR) ? 8'd0 : bumped;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				M_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(MAP_ENTRIES - 1)) begin
						state_q <= M_IDLE;
					end
				end
				M_IDLE: begin
					if (req.start) begin
						state_q <= M_READ;
					end
				end
				M_READ: begin
					state_q <= M_UPD;
				end
				M_UPD: begin
					state_q <= M_HOLD;
				end
				M_HOLD: begin
					if (ack) begin
						state_q <= M_IDLE;
					end
				end
				default: begin
					state_q <= M_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == M_IDLE) && req.start) begin
			addr_q <= req.slot[IDX_W-1:0];
			rec_q  <= req.record;
		end
		if (state_q == M_UPD) begin
			count_q <= rec_q ? bumped : rd_q;
			wrap_q  <= rec_q & at_max;
		end
	end

	assign clearing = (state_q == M_CLEAR);
	assign res = '{
		done:    (state_q == M_HOLD),
		slot:    cebu_pkg::slot_t'(addr_q),
		count:   count_q,
		wrapped: wrap_q
	};

endmodule

// File: sv/coverage_edge_bitmap_update.sv
// top level of the edge coverage bitmap update block
// Each request either records a traced location (hashed, combined with the
// previous location's hash and used to bump one byte counter, which saturates
// back to 128 after 255) or reads one counter. One request is in flight at a
// time: the time a record takes from acceptance to result is set by the
// single 32x32 multiplier that makes three passes for each of the two 64-bit
// products, and that of a read by the registered bitmap read. When MAP_ENTRIES
// is not a power of two the slot is reduced one bit per cycle, which lengthens
// both records and reads. After reset the bitmap is cleared one entry per
// cycle, with req_stall high throughout. The result register lets the next
// request be taken while a result is still waiting.
module coverage_edge_bitmap_update #(
	parameter int MAP_ENTRIES = 65536
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  cebu_pkg::req_t req,
	output logic           res_valid,
	input  logic           res_stall,
	output cebu_pkg::res_t res
);

	logic               busy_q;
	logic               res_valid_q;
	cebu_pkg::res_t     res_q;
	logic               clearing;
	logic               accept;
	logic               ack;
	cebu_pkg::map_req_t slot_req;
	cebu_pkg::map_res_t map_res;

	assign req_stall = busy_q | clearing;
	assign accept    = req_valid & ~req_stall;
	assign ack       = map_res.done & (~res_valid_q | ~res_stall);

	cebu_slot #(
		.MAP_ENTRIES (MAP_ENTRIES)
	) u_slot (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.item     (req),
		.slot_req (slot_req)
	);

	cebu_map #(
		.MAP_ENTRIES (MAP_ENTRIES)
	) u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (slot_req),
		.ack      (ack),
		.res      (map_res),
		.clearing (clearing)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (ack) begin
				busy_q <= 1'b0;
			end
			if (ack) begin
				res_valid_q <= 1'b1;
			end else if (~res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ack) begin
			res_q <= '{
				slot_index:  map_res.slot,
				count_value: map_res.count,
				wrapped:     map_res.wrapped
			};
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
